[sv/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    // Queue between the parser and the output stage
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    // One result item as it travels through the queue; the key byte is
    // applied in the output stage.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       fin;
        logic       has_byte;
        logic       frame_end;
    } t_item;

endpackage

[sv/wsd_front.sv]
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: tracks the frame phase, collects length and masking key,
// and pushes one queue entry for each payload byte or empty-frame marker.
// ----------------------------------------------------------------------------
module wsd_front
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_item      o_item
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

    logic [2:0]             r_phase,   n_phase;
    logic [3:0]             r_hdr_cnt, n_hdr_cnt;
    logic                   r_fin,     n_fin;
    logic [3:0]             r_opcode,  n_opcode;
    logic                   r_masked,  n_masked;
    logic [LENGTH_BITS-1:0] r_rem,     n_rem;
    logic [31:0]            r_key,     n_key;
    logic [1:0]             r_kidx,    n_kidx;

    logic [LENGTH_BITS-1:0] ext_len;
    logic [7:0]             key_byte;

    assign ext_len = {r_rem[LENGTH_BITS-9:0], i_byte};

    always_comb begin
        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_masked  = r_masked;
        n_rem     = r_rem;
        n_key     = r_key;
        n_kidx    = r_kidx;

        o_push           = 1'b0;
        o_item.data      = 8'd0;
        o_item.key       = 8'd0;
        o_item.opcode    = r_opcode;
        o_item.fin       = r_fin;
        o_item.has_byte  = 1'b0;
        o_item.frame_end = 1'b1;

        if (i_accept) begin
            case (r_phase)
                PH_HDR0: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_byte[7];
                    n_key    = 32'd0;
                    n_kidx   = 2'd0;
                    if (i_byte[6:0] == LEN_EXT16) begin
                        n_rem     = LEN_ZERO;
                        n_phase   = PH_EXTLEN;
                        n_hdr_cnt = 4'd2;
                    end else if (i_byte[6:0] == LEN_EXT64) begin
                        n_rem     = LEN_ZERO;
                        n_phase   = PH_EXTLEN;
                        n_hdr_cnt = 4'd8;
                    end else begin
                        n_rem = LENGTH_BITS'(i_byte[6:0]);
                        if (i_byte[7]) begin
                            n_phase   = PH_KEY;
                            n_hdr_cnt = 4'd4;
                        end else if (i_byte[6:0] == 7'd0) begin
                            // empty unmasked frame: emit the marker now
                            n_phase = PH_HDR0;
                            o_push  = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_rem     = ext_len;
                    n_hdr_cnt = r_hdr_cnt - 4'd1;
                    n_kidx    = 2'd0;
                    if (r_hdr_cnt == 4'd1) begin
                        if (r_masked) begin
                            n_phase   = PH_KEY;
                            n_hdr_cnt = 4'd4;
                        end else if (ext_len == LEN_ZERO) begin
                            n_phase = PH_HDR0;
                            o_push  = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_KEY: begin
                    n_key     = {r_key[23:0], i_byte};
                    n_hdr_cnt = r_hdr_cnt - 4'd1;
                    if (r_hdr_cnt == 4'd1) begin
                        if (r_rem == LEN_ZERO) begin
                            n_phase = PH_HDR0;
                            o_push  = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_kidx           = r_kidx + 2'd1;
                    n_rem            = r_rem - LEN_ONE;
                    o_push           = 1'b1;
                    o_item.data      = i_byte;
                    o_item.key       = r_masked ? key_byte : 8'd0;
                    o_item.has_byte  = 1'b1;
                    o_item.frame_end = (r_rem == LEN_ONE);
                    if (r_rem == LEN_ONE) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_hdr_cnt <= 4'd0;
            r_fin     <= 1'b0;
            r_opcode  <= 4'd0;
            r_masked  <= 1'b0;
            r_rem     <= LEN_ZERO;
            r_key     <= 32'd0;
            r_kidx    <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_fin     <= n_fin;
            r_opcode  <= n_opcode;
            r_masked  <= n_masked;
            r_rem     <= n_rem;
            r_key     <= n_key;
            r_kidx    <= n_kidx;
        end
    end

endmodule

[sv/wsd_queue.sv]
// ----------------------------------------------------------------------------
// wsd_queue
// Short FIFO of result items between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsd_queue
    import wsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    localparam logic [QUEUE_AW:0] COUNT_FULL = (QUEUE_AW+1)'(QUEUE_DEPTH);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count,  n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == COUNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[sv/wsd_back.sv]
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks the payload byte and holds the result in a
// register until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsd_back
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic [3:0] o_opcode,
    output logic       o_fin,
    output logic       o_has_byte,
    output logic       o_frame_end
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [3:0] r_opcode;
    logic       r_fin;
    logic       r_has_byte;
    logic       r_frame_end;

    // load whenever the register is empty or being drained
    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data      <= i_item.data ^ i_item.key;
            r_opcode    <= i_item.opcode;
            r_fin       <= i_item.fin;
            r_has_byte  <= i_item.has_byte;
            r_frame_end <= i_item.frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_opcode    = r_opcode;
    assign o_fin       = r_fin;
    assign o_has_byte  = r_has_byte;
    assign o_frame_end = r_frame_end;

endmodule

[sv/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket framing: parses headers from a byte stream and
// emits unmasked payload bytes tagged with opcode and fin.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tdata[7:0] raw stream byte
//  m_axis    out  tdata[7:0] payload byte, tuser opcode/fin/has_byte,
//                 tlast end of frame
//
//  One input transfer per cycle while the queue is not full; header and key
//  bytes produce nothing but an empty frame's marker. The queue is written
//  on the edge that accepts a byte; results are offered from the output
//  register, which loads from the queue while it is empty or being drained.
//  The four-entry queue sets how many results may wait while m_axis stalls
//  before s_axis_tready drops.
//  Synchronous active-low reset returns the parser to the first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [5:0] m_axis_tuser,   // [3:0] opcode, [4] fin, [5] has_byte
    output logic       m_axis_tlast    // frame_end
);

    logic  in_accept;
    logic  push;
    t_item push_item;
    logic  q_full;
    logic  q_empty;
    t_item q_item;
    logic  pop;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && !q_full;

    wsd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_item   (push_item)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    wsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_opcode    (m_axis_tuser[3:0]),
        .o_fin       (m_axis_tuser[4]),
        .o_has_byte  (m_axis_tuser[5]),
        .o_frame_end (m_axis_tlast)
    );

endmodule

[tb/sv/tb_websocket_frame_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Feeds raw frame bytes into the deframer and checks every payload result against
// a cycle-free software parser or a typed table row. A short table covers the
// empty frame, both extended lengths, masking and the reserved bits. Random
// frames follow, in three idle/stall regimes with a full drain between them.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

    import wsd_pkg::*;

    localparam int LENGTH_BITS = LENGTH_BITS_DEF;

    typedef enum logic [2:0] {
        PH_HEADER0,
        PH_HEADER1,
        PH_EXT_LEN,
        PH_KEY,
        PH_PAYLOAD
    } frame_phase_e;

    typedef enum logic [1:0] {
        ROW_QUIET,      // header or key byte, no result
        ROW_RESULT,     // result typed in the table
        ROW_PREDICT     // result taken from the parser model
    } row_kind_e;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] opcode;
        logic       fin;
        logic       has_byte;
        logic       frame_end;
    } payload_result_t;

    typedef struct packed {
        logic [7:0]      data;
        row_kind_e       kind;
        payload_result_t res;
    } stim_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] payload_byte
    logic [5:0] m_axis_tuser;           // [3:0] opcode, [4] fin, [5] has_byte
    logic       m_axis_tlast;           // frame_end

    websocket_frame_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Parser model state, reset values
    frame_phase_e           parse_phase  = PH_HEADER0;
    logic [3:0]             header_left  = 4'd0;
    logic                   frame_fin    = 1'b0;
    logic [3:0]             frame_opcode = 4'd0;
    logic                   frame_masked = 1'b0;
    logic [LENGTH_BITS-1:0] remaining    = '0;
    logic [31:0]            mask_key     = 32'd0;
    logic [1:0]             key_pos      = 2'd0;

    payload_result_t expected_results[$];
    stim_row_t       directed_rows[$];
    int              mismatch_count = 0;
    int              bytes_sent = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    function automatic payload_result_t empty_marker();
        payload_result_t r;
        begin
            r.payload_byte = 8'h00;
            r.opcode       = frame_opcode;
            r.fin          = frame_fin;
            r.has_byte     = 1'b0;
            r.frame_end    = 1'b1;
            return r;
        end
    endfunction

    // Length is complete: move to key, payload, or emit the empty marker.
    function automatic bit finish_length(output payload_result_t r);
        begin
            r = '0;
            key_pos = 2'd0;
            if (frame_masked) begin
                parse_phase = PH_KEY;
                header_left = 4'd4;
                return 1'b0;
            end
            if (remaining == '0) begin
                parse_phase = PH_HEADER0;
                r = empty_marker();
                return 1'b1;
            end
            parse_phase = PH_PAYLOAD;
            return 1'b0;
        end
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output payload_result_t r);
        logic [7:0] k;
        bit         produced;
        begin
            produced = 1'b0;
            r = '0;
            k = 8'h00;
            case (parse_phase)
                PH_HEADER0: begin
                    frame_fin    = b[7];
                    frame_opcode = b[3:0];
                    parse_phase  = PH_HEADER1;
                end
                PH_HEADER1: begin
                    frame_masked = b[7];
                    mask_key     = 32'd0;
                    remaining    = '0;
                    if (b[6:0] == 7'd126) begin
                        parse_phase = PH_EXT_LEN;
                        header_left = 4'd2;
                    end else if (b[6:0] == 7'd127) begin
                        parse_phase = PH_EXT_LEN;
                        header_left = 4'd8;
                    end else begin
                        remaining = LENGTH_BITS'(b[6:0]);
                        produced  = finish_length(r);
                    end
                end
                PH_EXT_LEN: begin
                    remaining   = {remaining[LENGTH_BITS-9:0], b};
                    header_left = header_left - 4'd1;
                    if (header_left == 4'd0)
                        produced = finish_length(r);
                end
                PH_KEY: begin
                    mask_key    = {mask_key[23:0], b};
                    header_left = header_left - 4'd1;
                    if (header_left == 4'd0) begin
                        if (remaining == '0) begin
                            parse_phase = PH_HEADER0;
                            r = empty_marker();
                            produced = 1'b1;
                        end else begin
                            parse_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (frame_masked)
                        k = mask_key[8*(3 - key_pos) +: 8];
                    key_pos   = key_pos + 2'd1;
                    remaining = remaining - 1'b1;
                    r.payload_byte = b ^ k;
                    r.opcode       = frame_opcode;
                    r.fin          = frame_fin;
                    r.has_byte     = 1'b1;
                    r.frame_end    = (remaining == '0);
                    if (remaining == '0)
                        parse_phase = PH_HEADER0;
                    produced = 1'b1;
                end
                default: begin
                    parse_phase = PH_HEADER0;
                end
            endcase
            return produced;
        end
    endfunction

    // Drive one byte, hold it until transfer, then record what it should cause.
    task automatic send_byte(input logic [7:0] b, input row_kind_e kind,
                             input payload_result_t typed);
        payload_result_t predicted;
        bit              produced;
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= b;
            @(posedge i_clk);
            while (!s_axis_tready)
                @(posedge i_clk);
            bytes_sent++;
            produced = deframe_byte(b, predicted);
            if (kind == ROW_RESULT)
                expected_results.push_back(typed);
            else if (kind == ROW_PREDICT && produced)
                expected_results.push_back(predicted);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input row_kind_e kind,
                           input payload_result_t res);
        stim_row_t row;
        begin
            row.data = b;
            row.kind = kind;
            row.res  = res;
            directed_rows.push_back(row);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0]  hdr0;
        logic        masked;
        int          sel;
        int          len;
        logic [63:0] len64;
        begin
            hdr0   = 8'($urandom_range(255));
            masked = 1'($urandom_range(1));
            sel    = $urandom_range(99);
            send_byte(hdr0, ROW_PREDICT, '0);
            if (sel < 70) begin
                len = (sel < 6) ? $urandom_range(125) : $urandom_range(24);
                send_byte({masked, 7'(len)}, ROW_PREDICT, '0);
            end else if (sel < 85) begin
                // 16-bit length, often a non-minimal encoding
                len = (sel < 73) ? $urandom_range(300) : $urandom_range(40);
                send_byte({masked, 7'd126}, ROW_PREDICT, '0);
                send_byte(8'(len >> 8), ROW_PREDICT, '0);
                send_byte(8'(len), ROW_PREDICT, '0);
            end else begin
                len   = $urandom_range(40);
                len64 = 64'(len);
                send_byte({masked, 7'd127}, ROW_PREDICT, '0);
                for (int i = 7; i >= 0; i--)
                    send_byte(len64[8*i +: 8], ROW_PREDICT, '0);
            end
            if (masked)
                for (int i = 0; i < 4; i++)
                    send_byte(8'($urandom_range(255)), ROW_PREDICT, '0);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(255)), ROW_PREDICT, '0);
        end
    endtask

    // Pause the sender until every pending result has come out.
    task automatic drain_results();
        begin
            s_axis_tvalid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        payload_result_t exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%h tlast=%b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_axis_tdata !== exp_res.payload_byte) begin
                    $error("payload_byte: expected %h, actual %h",
                           exp_res.payload_byte, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser[3:0] !== exp_res.opcode) begin
                    $error("opcode: expected %h, actual %h",
                           exp_res.opcode, m_axis_tuser[3:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[4] !== exp_res.fin) begin
                    $error("fin: expected %b, actual %b", exp_res.fin, m_axis_tuser[4]);
                    mismatch_count++;
                end
                if (m_axis_tuser[5] !== exp_res.has_byte) begin
                    $error("has_byte: expected %b, actual %b",
                           exp_res.has_byte, m_axis_tuser[5]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_res.frame_end) begin
                    $error("frame_end: expected %b, actual %b",
                           exp_res.frame_end, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        // Empty final ping: marker right after the length byte
        add_row(8'h89, ROW_QUIET,  '0);
        add_row(8'h00, ROW_RESULT, {8'h00, 4'h9, 1'b1, 1'b0, 1'b1});
        // Unmasked text fragment, payload extremes
        add_row(8'h01, ROW_QUIET,  '0);
        add_row(8'h02, ROW_QUIET,  '0);
        add_row(8'h00, ROW_RESULT, {8'h00, 4'h1, 1'b0, 1'b1, 1'b0});
        add_row(8'hFF, ROW_RESULT, {8'hFF, 4'h1, 1'b0, 1'b1, 1'b1});
        // Masked binary with a non-minimal 16-bit length of one
        add_row(8'h82, ROW_QUIET,   '0);
        add_row(8'hFE, ROW_QUIET,   '0);
        add_row(8'h00, ROW_QUIET,   '0);
        add_row(8'h01, ROW_QUIET,   '0);
        add_row(8'hFF, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'hAA, ROW_PREDICT, '0);
        add_row(8'h55, ROW_PREDICT, '0);
        add_row(8'h0F, ROW_PREDICT, '0);
        // Masked empty close: marker on the last key byte
        add_row(8'h88, ROW_QUIET,  '0);
        add_row(8'h80, ROW_QUIET,  '0);
        add_row(8'h12, ROW_QUIET,  '0);
        add_row(8'h34, ROW_QUIET,  '0);
        add_row(8'h56, ROW_QUIET,  '0);
        add_row(8'h78, ROW_RESULT, {8'h00, 4'h8, 1'b1, 1'b0, 1'b1});
        // Reserved bits set, unknown opcode, 64-bit length of zero
        add_row(8'h7A, ROW_QUIET, '0);
        add_row(8'h7F, ROW_QUIET, '0);
        for (int i = 0; i < 7; i++)
            add_row(8'h00, ROW_QUIET, '0);
        add_row(8'h00, ROW_RESULT, {8'h00, 4'hA, 1'b0, 1'b0, 1'b1});

        send_idle_pct  = 25;
        recv_stall_pct = 69;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].kind, directed_rows[i].res);
        while (bytes_sent < 270)
            send_random_frame();

        drain_results();
        send_idle_pct  = 69;
        recv_stall_pct = 25;
        while (bytes_sent < 540)
            send_random_frame();

        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (bytes_sent < 800)
            send_random_frame();

        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("websocket_frame_deframer: match");
        else
            $display("websocket_frame_deframer: mismatch");
        $finish;
    end

    initial begin
        #4000000;
        $display("websocket_frame_deframer: mismatch");
        $finish;
    end

endmodule
